// ----- rtl/core/brf_pkg.sv -----
`default_nettype none

package brf_pkg;

    // Storage geometry
    localparam int DEPTH   = 4096;
    localparam int LANES   = 8;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ROWS    = DEPTH / LANES;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Field widths
    localparam int COUNT_W = 4;
    localparam int DATA_W  = 64;
    localparam int FILL_W  = 13;

    // Request kinds
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    typedef logic [7:0] byte_t;

    // One bank access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ROW_W-1:0]  row;
        byte_t             wdata;
    } lane_req_t;

    // Context the merge stage needs to line up a get
    typedef struct packed {
        logic               is_get;
        logic [LANE_W-1:0]  rot;
        logic [COUNT_W-1:0] moved;
    } merge_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/brf_lane.sv -----
`default_nettype none

module brf_lane (
    input  wire                         aclk,
    input  wire brf_pkg::lane_req_t     req,
    output brf_pkg::byte_t              rdata
);
    import brf_pkg::*;

    byte_t mem [ROWS];
    byte_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.row] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.row];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/brf_merge.sv -----
`default_nettype none

module brf_merge (
    input  wire brf_pkg::merge_ctl_t    ctl,
    input  wire brf_pkg::byte_t         rdata [brf_pkg::LANES],
    output logic [brf_pkg::DATA_W-1:0]  read_bytes
);
    import brf_pkg::*;

    logic [LANE_W-1:0] src;

    // Rotate banks back into request order, zero past the delivered count.
    always_comb begin
        read_bytes = '0;
        src        = '0;
        for (int i = 0; i < LANES; i++) begin
            src = ctl.rot + LANE_W'(i);
            if (ctl.is_get && (COUNT_W'(i) < ctl.moved)) begin
                read_bytes[8*i +: 8] = rdata[src];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/byte_ring_fifo.sv -----
`default_nettype none

// Byte ring FIFO, 4096 bytes, split into 8 byte-wide banks (byte address a
// lives in bank a mod 8, row a / 8), so one request touches each bank at most
// once. A put offers up to 8 bytes in the low lanes of s_write_bytes; the
// block stores as many as fit and reports that count. A get asks for up to 8
// bytes; the oldest held byte comes back in lane 0, lanes past the delivered
// count are zero. Every request yields one response carrying the fill level
// after it. byte_count above 8 is treated as 8. Write and read counters are
// free-running over twice the depth, so full and empty are told apart
// without a flag. Throughput: one request per cycle while the output side is
// not stalled by m_ready. On acceptance a request loads the bank read
// registers and stage 1; its merged result then moves into the output
// register, which raises m_valid. Data written by a put is visible to a get
// accepted on the very next cycle. No clearing pass after reset: bytes are
// never read before they are written.
module byte_ring_fifo (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_req_type,
    input  wire [brf_pkg::COUNT_W-1:0]   s_byte_count,
    input  wire [brf_pkg::DATA_W-1:0]    s_write_bytes,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [brf_pkg::COUNT_W-1:0]  m_moved_count,
    output logic [brf_pkg::DATA_W-1:0]   m_read_bytes,
    output logic [brf_pkg::FILL_W-1:0]   m_fill_level
);
    import brf_pkg::*;

    // Counters
    logic [CNT_W-1:0]   wc_reg, wc_next;
    logic [CNT_W-1:0]   rc_reg, rc_next;

    // Bank read stage
    logic               s1_valid_reg, s1_valid_next;
    merge_ctl_t         s1_ctl_reg;
    logic [FILL_W-1:0]  s1_fill_reg;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_moved_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic [FILL_W-1:0]   m_fill_reg;

    logic               accept;
    logic               out_free;
    logic               s1_move;
    logic               is_get;
    logic [COUNT_W-1:0] want;
    logic [CNT_W-1:0]   fill;
    logic [CNT_W-1:0]   room;
    logic [CNT_W-1:0]   limit;
    logic [COUNT_W-1:0] moved;
    logic [CNT_W-1:0]   fill_after;
    logic [ADDR_W-1:0]  base;

    lane_req_t          lane_req [LANES];
    byte_t              lane_rdata [LANES];
    logic [DATA_W-1:0]  merged;

    // Handshake: stage 1 drains whenever the output register is free or
    // being emptied, and a new request may enter whenever stage 1 is empty or drains.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // Clip, then bound by free room (put) or held bytes (get).
    always_comb begin
        is_get = (s_req_type == REQ_GET);
        want   = (s_byte_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : s_byte_count;
        fill   = wc_reg - rc_reg;
        room   = CNT_W'(DEPTH) - fill;
        limit  = is_get ? fill : room;
        moved  = (CNT_W'(want) < limit) ? want : limit[COUNT_W-1:0];
        fill_after = is_get ? (fill - CNT_W'(moved)) : (fill + CNT_W'(moved));
        base   = is_get ? rc_reg[ADDR_W-1:0] : wc_reg[ADDR_W-1:0];

        wc_next = wc_reg;
        rc_next = rc_reg;
        if (accept) begin
            if (is_get) begin
                rc_next = rc_reg + CNT_W'(moved);
            end else begin
                wc_next = wc_reg + CNT_W'(moved);
            end
        end
    end

    // One bank per lane. Bank b holds the byte at request offset
    // (b - base) mod LANES; its row follows from the full address.
    for (genvar b = 0; b < LANES; b++) begin : g_lane
        logic [LANE_W-1:0] off;
        logic [ADDR_W-1:0] addr;

        always_comb begin
            off  = LANE_W'(b) - base[LANE_W-1:0];
            addr = base + ADDR_W'(off);
            lane_req[b].row   = addr[ADDR_W-1:ADDR_W-ROW_W];
            lane_req[b].wdata = s_write_bytes[8*off +: 8];
            lane_req[b].we    = accept && !is_get && (COUNT_W'(off) < moved);
            lane_req[b].re    = accept && is_get;
        end

        brf_lane u_lane (
            .aclk  (aclk),
            .req   (lane_req[b]),
            .rdata (lane_rdata[b])
        );
    end

    // Merge: rotate bank outputs into request order and mask.
    brf_merge u_merge (
        .ctl        (s1_ctl_reg),
        .rdata      (lane_rdata),
        .read_bytes (merged)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg       <= '0;
            rc_reg       <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            wc_reg       <= wc_next;
            rc_reg       <= rc_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg.is_get <= is_get;
            s1_ctl_reg.rot    <= base[LANE_W-1:0];
            s1_ctl_reg.moved  <= moved;
            s1_fill_reg       <= FILL_W'(fill_after);
        end
        if (s1_move) begin
            m_moved_reg <= s1_ctl_reg.moved;
            m_data_reg  <= merged;
            m_fill_reg  <= s1_fill_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_moved_count = m_moved_reg;
    assign m_read_bytes  = m_data_reg;
    assign m_fill_level  = m_fill_reg;

endmodule

`default_nettype wire

// ----- rtl/core/brf_checker.sv -----
`default_nettype none

module brf_checker (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_ready,
    input  wire                          m_valid,
    input  wire                          m_ready,
    input  wire [brf_pkg::COUNT_W-1:0]   m_moved_count,
    input  wire [brf_pkg::DATA_W-1:0]    m_read_bytes,
    input  wire [brf_pkg::FILL_W-1:0]    m_fill_level
);
    import brf_pkg::*;

    // A stalled response holds.
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_moved_count)
            && $stable(m_read_bytes) && $stable(m_fill_level))
        else $error("response changed while stalled");

    a_moved_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_moved_count <= COUNT_W'(LANES))
        else $error("moved count above lane count");

    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fill_level <= FILL_W'(DEPTH))
        else $error("fill level above depth");

    // Nothing moved means no data lanes.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_moved_count == '0) |-> m_read_bytes == '0)
        else $error("data present with zero count");

    // Out of reset: no response pending, ready for a request.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);

`default_nettype wire
